FILE: hdl/bss_pkg.sv
// Shared constants for the brew shot sequencer.
package bss_pkg;

    // Shot timer storage width and its saturation value.
    localparam int unsigned SHOT_TIMER_BITS = 15;
    localparam logic [SHOT_TIMER_BITS-1:0] SHOT_MAX = {SHOT_TIMER_BITS{1'b1}};

    // Field widths.
    localparam int unsigned PROG_BITS  = 10;
    localparam int unsigned IDLE_BITS  = 16;
    localparam int unsigned WARN_BITS  = 4;
    localparam int unsigned CODE_BITS  = 3;
    localparam int unsigned SHOT_OUT_BITS = 15;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSURIZE_END  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PREINFUSE_END   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOAK_END        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_START_END = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULL_END        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_START     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_LIMIT      = 3'd6;

    // Configuration reset values.
    localparam logic [PROG_BITS-1:0] RST_PRESSURIZE_END  = 10'd100;
    localparam logic [PROG_BITS-1:0] RST_PREINFUSE_END   = 10'd110;
    localparam logic [PROG_BITS-1:0] RST_SOAK_END        = 10'd140;
    localparam logic [PROG_BITS-1:0] RST_PULSE_START_END = 10'd150;
    localparam logic [PROG_BITS-1:0] RST_PULL_END        = 10'd801;
    localparam logic [PROG_BITS-1:0] RST_ALARM_START     = 10'd851;
    localparam logic [IDLE_BITS-1:0] RST_IDLE_LIMIT      = 16'd12500;

    // Switch codes.
    localparam logic [CODE_BITS-1:0] SW_NONE  = 3'd0;
    localparam logic [CODE_BITS-1:0] SW_BREW  = 3'd1;
    localparam logic [CODE_BITS-1:0] SW_WATER = 3'd3;

    // Alarm window bounds and offsets.
    localparam logic [PROG_BITS-1:0] ALARM_MIN      = 10'd26;
    localparam logic [PROG_BITS-1:0] ALARM_MAX      = 10'd1017;
    localparam logic [PROG_BITS-1:0] ALARM_PULSE    = 10'd5;
    localparam logic [PROG_BITS-1:0] ALARM_SOLID    = 10'd25;
    localparam logic [PROG_BITS-1:0] PROG_MAX       = 10'd1023;
    localparam logic [WARN_BITS-1:0] WARN_SAT       = 4'd15;
    localparam logic [WARN_BITS-1:0] WARN_SOLID     = 4'd10;

endpackage

FILE: hdl/brew_shot_sequencer.sv
// Espresso shot sequencer: one control-loop pass per accepted word.
// A word is registered at the input; its pass, combinational compare and count logic,
// then updates the state and result registers when the result register can take it.
// Throughput: one word per cycle, unless the output stalls.
// The input register holds a word while a finished result waits on a stalled output.
// Reset (synchronous, active low) clears all state and loads the default configuration.
module brew_shot_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [bss_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_power_on,
    input  logic                               i_tick_event,
    input  logic [bss_pkg::CODE_BITS-1:0]      i_switch_code,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pump_on,
    output logic                               o_water_valve_on,
    output logic                               o_tank_valve_on,
    output logic                               o_buzzer_on,
    output logic [bss_pkg::SHOT_OUT_BITS-1:0]  o_shot_time,
    output logic                               o_timer_run
);

    // Configuration registers
    logic [bss_pkg::PROG_BITS-1:0] r_pressurize_end, r_preinfuse_end, r_soak_end;
    logic [bss_pkg::PROG_BITS-1:0] r_pulse_start_end, r_pull_end, r_alarm_start;
    logic [bss_pkg::IDLE_BITS-1:0] r_idle_limit;

    // Input register
    logic                          r_in_valid;
    logic                          r_in_power;
    logic                          r_in_tick;
    logic [bss_pkg::CODE_BITS-1:0] r_in_code;

    // Sequencer state, which also forms the result register
    logic                                r_out_valid;
    logic                                r_brew_latched, r_water_latched, r_tick_pending;
    logic                                r_timer_on;
    logic [bss_pkg::PROG_BITS-1:0]       r_progress;
    logic [bss_pkg::WARN_BITS-1:0]       r_warn_count;
    logic [bss_pkg::IDLE_BITS-1:0]       r_idle_count;
    logic [bss_pkg::SHOT_TIMER_BITS-1:0] r_shot_count;
    logic                                r_pump, r_wvalve, r_tvalve, r_buzz;

    logic                                n_brew_latched, n_water_latched, n_tick_pending;
    logic                                n_timer_on;
    logic [bss_pkg::PROG_BITS-1:0]       n_progress;
    logic [bss_pkg::WARN_BITS-1:0]       n_warn_count;
    logic [bss_pkg::IDLE_BITS-1:0]       n_idle_count;
    logic [bss_pkg::SHOT_TIMER_BITS-1:0] n_shot_count;
    logic                                n_pump, n_wvalve, n_tvalve, n_buzz;

    logic in_take;
    logic out_take;
    logic advance;

    // Handshake: a pass runs when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressurize_end  <= bss_pkg::RST_PRESSURIZE_END;
            r_preinfuse_end   <= bss_pkg::RST_PREINFUSE_END;
            r_soak_end        <= bss_pkg::RST_SOAK_END;
            r_pulse_start_end <= bss_pkg::RST_PULSE_START_END;
            r_pull_end        <= bss_pkg::RST_PULL_END;
            r_alarm_start     <= bss_pkg::RST_ALARM_START;
            r_idle_limit      <= bss_pkg::RST_IDLE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bss_pkg::CFG_PRESSURIZE_END:  r_pressurize_end  <= i_cfg_data[9:0];
                bss_pkg::CFG_PREINFUSE_END:   r_preinfuse_end   <= i_cfg_data[9:0];
                bss_pkg::CFG_SOAK_END:        r_soak_end        <= i_cfg_data[9:0];
                bss_pkg::CFG_PULSE_START_END: r_pulse_start_end <= i_cfg_data[9:0];
                bss_pkg::CFG_PULL_END:        r_pull_end        <= i_cfg_data[9:0];
                bss_pkg::CFG_ALARM_START:     r_alarm_start     <= i_cfg_data[9:0];
                bss_pkg::CFG_IDLE_LIMIT:      r_idle_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_power <= i_power_on;
            r_in_tick  <= i_tick_event;
            r_in_code  <= i_switch_code;
        end
    end

    // One pass of the control loop.
    always_comb begin
        logic [bss_pkg::PROG_BITS-1:0] p;
        logic [bss_pkg::PROG_BITS-1:0] w;
        logic                          tk;

        n_brew_latched  = r_brew_latched;
        n_water_latched = r_water_latched;
        n_tick_pending  = r_tick_pending | (r_in_tick & r_timer_on);
        n_timer_on      = r_timer_on;
        n_progress      = r_progress;
        n_warn_count    = r_warn_count;
        n_idle_count    = r_idle_count;
        n_shot_count    = r_shot_count;
        n_pump          = r_pump;
        n_wvalve        = r_wvalve;
        n_tvalve        = r_tvalve;
        n_buzz          = r_buzz;
        p               = r_progress;
        tk              = n_tick_pending;

        // Alarm start is clamped into its usable window.
        if (r_alarm_start < bss_pkg::ALARM_MIN) begin
            w = bss_pkg::ALARM_MIN;
        end else if (r_alarm_start > bss_pkg::ALARM_MAX) begin
            w = bss_pkg::ALARM_MAX;
        end else begin
            w = r_alarm_start;
        end

        if (r_in_power) begin
            if (r_brew_latched) begin
                n_timer_on   = 1'b1;
                n_idle_count = '0;

                // Phase windows are checked in order; they may overlap when misconfigured.
                if (p <= r_pressurize_end) begin
                    n_pump   = 1'b1;
                    n_tvalve = 1'b1;
                end
                if (p > r_pressurize_end && p <= r_preinfuse_end) begin
                    n_tvalve = 1'b0;
                    n_wvalve = 1'b1;
                    if (tk) begin
                        n_pump = !n_pump;
                    end
                end
                if (p > r_preinfuse_end && p <= r_soak_end) begin
                    n_pump = 1'b0;
                end
                if (p > r_soak_end && p <= r_pulse_start_end) begin
                    n_wvalve = 1'b1;
                    if (tk) begin
                        n_pump = !n_pump;
                    end
                end
                if (p > r_pulse_start_end && p <= r_pull_end) begin
                    n_wvalve = 1'b1;
                    n_tvalve = 1'b1;
                    n_pump   = 1'b0;
                end

                // Buzzer pulses a number of times, then stays on.
                if (p >= w) begin
                    n_buzz = 1'b1;
                end
                if (p >= w + bss_pkg::ALARM_PULSE) begin
                    n_buzz = 1'b0;
                    p      = w - bss_pkg::ALARM_PULSE;
                    if (n_warn_count < bss_pkg::WARN_SAT) begin
                        n_warn_count = n_warn_count + 4'd1;
                    end
                end
                if (n_warn_count >= bss_pkg::WARN_SOLID) begin
                    n_buzz       = 1'b1;
                    p            = w - bss_pkg::ALARM_SOLID;
                    n_warn_count = bss_pkg::WARN_SOLID;
                end

                // Shot timer counts ticks with the water valve open.
                if (n_wvalve && tk && n_shot_count != bss_pkg::SHOT_MAX) begin
                    n_shot_count = n_shot_count + 1'b1;
                end
                if (tk) begin
                    n_tick_pending = 1'b0;
                    if (p != bss_pkg::PROG_MAX) begin
                        p = p + 10'd1;
                    end
                end
                n_progress = p;
            end else begin
                n_buzz       = 1'b0;
                n_warn_count = '0;
                n_timer_on   = 1'b0;
                n_progress   = '0;
                if (n_idle_count < r_idle_limit) begin
                    n_idle_count = n_idle_count + 16'd1;
                end
                if (n_idle_count >= r_idle_limit) begin
                    n_shot_count = '0;
                end
            end
            if (r_water_latched) begin
                n_pump   = 1'b1;
                n_wvalve = 1'b1;
            end
        end else begin
            n_shot_count = '0;
            n_pump       = 1'b0;
            n_wvalve     = 1'b0;
            n_tvalve     = 1'b0;
            n_buzz       = 1'b0;
        end

        // Switch codes are latched at the end of the pass.
        if (r_in_code == bss_pkg::SW_BREW) begin
            n_brew_latched = 1'b1;
        end
        if (r_in_code == bss_pkg::SW_WATER) begin
            n_water_latched = 1'b1;
        end
        if (r_in_code == bss_pkg::SW_NONE) begin
            n_brew_latched  = 1'b0;
            n_water_latched = 1'b0;
            n_pump          = 1'b0;
            n_wvalve        = 1'b0;
            n_tvalve        = 1'b0;
        end
    end

    // State and result registers, updated once per pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_brew_latched  <= 1'b0;
            r_water_latched <= 1'b0;
            r_tick_pending  <= 1'b0;
            r_timer_on      <= 1'b0;
            r_progress      <= '0;
            r_warn_count    <= '0;
            r_idle_count    <= '0;
            r_shot_count    <= '0;
            r_pump          <= 1'b0;
            r_wvalve        <= 1'b0;
            r_tvalve        <= 1'b0;
            r_buzz          <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_brew_latched  <= n_brew_latched;
                r_water_latched <= n_water_latched;
                r_tick_pending  <= n_tick_pending;
                r_timer_on      <= n_timer_on;
                r_progress      <= n_progress;
                r_warn_count    <= n_warn_count;
                r_idle_count    <= n_idle_count;
                r_shot_count    <= n_shot_count;
                r_pump          <= n_pump;
                r_wvalve        <= n_wvalve;
                r_tvalve        <= n_tvalve;
                r_buzz          <= n_buzz;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word comes straight from the state registers.
    assign o_out_valid      = r_out_valid;
    assign o_pump_on        = r_pump;
    assign o_water_valve_on = r_wvalve;
    assign o_tank_valve_on  = r_tvalve;
    assign o_buzzer_on      = r_buzz;
    assign o_shot_time      = bss_pkg::SHOT_OUT_BITS'(r_shot_count);
    assign o_timer_run      = r_timer_on;

    // The input side only stalls while a word is already held.
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // The warning count never passes the solid-buzzer level.
    a_warn_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warn_count <= bss_pkg::WARN_SOLID)
        else $error("warning count out of range");

    // A pass with power off leaves all actuators off and the shot timer clear.
    a_power_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_power |=> !o_pump_on && !o_water_valve_on && !o_tank_valve_on
                                   && !o_buzzer_on && r_shot_count == '0)
        else $error("power off pass left outputs active");

    // A powered pass without brew stops the tick timer.
    a_idle_stops_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_power && !r_brew_latched |=> !o_timer_run)
        else $error("timer still running after an idle pass");

endmodule
